// File: hdl/cau_pkg.sv
package cau_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned CMD_W         = 3;
  localparam int unsigned PROD_W        = 2 * DATA_W;
  localparam int unsigned SUM_W         = PROD_W + 2;
  localparam int unsigned REM_W         = PROD_W + 1;
  localparam int unsigned IN_DATA_W     = 4 * DATA_W;
  localparam int unsigned OUT_DATA_W    = 72;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_EQ  = 3'd4,
    CMD_NE  = 3'd5
  } cmd_t;

  // One beat inside the divider stages; both quotients advance together.
  typedef struct packed {
    logic              valid;
    logic [CMD_W-1:0]  cmd;
    logic              cmp;
    logic              dz;
    logic              neg_re;
    logic              neg_im;
    logic              big_re;
    logic              big_im;
    logic [PROD_W-1:0] mag_re;
    logic [PROD_W-1:0] mag_im;
    logic [PROD_W-1:0] den;
    logic [REM_W-1:0]  rem_re;
    logic [REM_W-1:0]  rem_im;
    logic [DATA_W-1:0] nlo_re;
    logic [DATA_W-1:0] nlo_im;
    logic [DATA_W-1:0] q_re;
    logic [DATA_W-1:0] q_im;
  } div_beat_t;

endpackage

// File: hdl/complex_arithmetic_unit.sv
// Channel   Dir  tdata (low bit up)                          tuser
// s_axis    in   a_re[31:0] a_im[63:32] b_re[95:64]          command[2:0]
//                b_im[127:96]
// m_axis    out  res_re[31:0] res_im[63:32] compare_true[64]  -
//                div_zero[65] overflow[66], zero to [71]
// One beat is accepted per cycle while the output is not stalled; every command
// passes through the same registers from input beat to output beat, including the 32 quotient stages of the divider.
// The pipeline is stateless apart from its valid bits, which reset clears.
// When the output beat is not taken, every stage holds and s_axis_tready falls.
module complex_arithmetic_unit #(
  parameter int unsigned FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [cau_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // a_re, a_im, b_re, b_im
  input  logic [cau_pkg::CMD_W-1:0]         s_axis_tuser,  // command
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [cau_pkg::OUT_DATA_W-1:0]    m_axis_tdata   // res_re, res_im, compare_true,
                                                           // div_zero, overflow
);

  localparam int unsigned DW  = cau_pkg::DATA_W;
  localparam int unsigned PW  = cau_pkg::PROD_W;
  localparam int unsigned SW  = cau_pkg::SUM_W;
  localparam int unsigned RW  = cau_pkg::REM_W;
  localparam int unsigned CW  = cau_pkg::CMD_W;
  localparam int unsigned NW  = PW + FRAC_BITS;

  logic adv;

  // Stage 1: input register.
  logic                 v1;
  logic [CW-1:0]        cmd1;
  logic signed [DW-1:0] ar1, ai1, br1, bi1;

  // Stage 2: products, sums of parts, flags.
  logic                 v2;
  logic [CW-1:0]        cmd2;
  logic                 cmp2, dz2;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir, sq_r, sq_i;
  logic signed [DW:0]   as_re2, as_im2;

  // Stage 3: exact signed sums and divisor.
  logic                 v3;
  logic [CW-1:0]        cmd3;
  logic                 cmp3, dz3;
  logic signed [SW-1:0] sum_re3, sum_im3;
  logic [PW-1:0]        den3;

  // Stage 4: sign and magnitude.
  logic                 v4;
  logic [CW-1:0]        cmd4;
  logic                 cmp4, dz4, neg_re4, neg_im4;
  logic [PW-1:0]        mag_re4, mag_im4, den4;
  logic [SW-1:0]        abs_re, abs_im;

  cau_pkg::div_beat_t   dv [0:DW];
  logic [NW-1:0]        num_re, num_im;
  logic [RW-1:0]        hi_re, hi_im, den_x;

  logic                 ov;
  logic [DW-1:0]        o_re, o_im;
  logic                 o_cmp, o_dz, o_ovf;

  assign adv           = !ov || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd1 <= s_axis_tuser;
      ar1  <= s_axis_tdata[DW-1:0];
      ai1  <= s_axis_tdata[2*DW-1:DW];
      br1  <= s_axis_tdata[3*DW-1:2*DW];
      bi1  <= s_axis_tdata[4*DW-1:3*DW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd2 <= cmd1;
      p_rr <= ar1 * br1;
      p_ii <= ai1 * bi1;
      p_ri <= ar1 * bi1;
      p_ir <= ai1 * br1;
      sq_r <= br1 * br1;
      sq_i <= bi1 * bi1;
      if (cmd1 == cau_pkg::CMD_SUB) begin
        as_re2 <= (DW+1)'(ar1) - (DW+1)'(br1);
        as_im2 <= (DW+1)'(ai1) - (DW+1)'(bi1);
      end else begin
        as_re2 <= (DW+1)'(ar1) + (DW+1)'(br1);
        as_im2 <= (DW+1)'(ai1) + (DW+1)'(bi1);
      end
      case (cmd1)
        cau_pkg::CMD_EQ: cmp2 <= (ar1 == br1) && (ai1 == bi1);
        cau_pkg::CMD_NE: cmp2 <= (ar1 != br1) || (ai1 != bi1);
        default:         cmp2 <= 1'b0;
      endcase
      dz2 <= (cmd1 == cau_pkg::CMD_DIV) && (br1 == '0) && (bi1 == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd3 <= cmd2;
      cmp3 <= cmp2;
      dz3  <= dz2;
      den3 <= PW'(sq_r) + PW'(sq_i);
      case (cmd2)
        cau_pkg::CMD_MUL: begin
          sum_re3 <= SW'(p_rr) - SW'(p_ii);
          sum_im3 <= SW'(p_ri) + SW'(p_ir);
        end
        cau_pkg::CMD_DIV: begin
          sum_re3 <= SW'(p_rr) + SW'(p_ii);
          sum_im3 <= SW'(p_ir) - SW'(p_ri);
        end
        default: begin
          sum_re3 <= SW'(as_re2);
          sum_im3 <= SW'(as_im2);
        end
      endcase
    end
  end

  assign abs_re = sum_re3[SW-1] ? SW'(-sum_re3) : SW'(sum_re3);
  assign abs_im = sum_im3[SW-1] ? SW'(-sum_im3) : SW'(sum_im3);

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd4    <= cmd3;
      cmp4    <= cmp3;
      dz4     <= dz3;
      den4    <= den3;
      neg_re4 <= sum_re3[SW-1];
      neg_im4 <= sum_im3[SW-1];
      if (cmd3 == cau_pkg::CMD_MUL) begin
        mag_re4 <= abs_re[PW-1:0] >> FRAC_BITS;
        mag_im4 <= abs_im[PW-1:0] >> FRAC_BITS;
      end else begin
        mag_re4 <= abs_re[PW-1:0];
        mag_im4 <= abs_im[PW-1:0];
      end
    end
  end

  // Dividend is the magnitude scaled by the fraction; its upper part seeds the
  // remainder, and a seed not below the divisor means the quotient overflows.
  assign num_re = NW'(mag_re4) << FRAC_BITS;
  assign num_im = NW'(mag_im4) << FRAC_BITS;
  assign hi_re  = RW'(num_re[NW-1:DW]);
  assign hi_im  = RW'(num_im[NW-1:DW]);
  assign den_x  = RW'(den4);

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].valid <= 1'b0;
    end else if (adv) begin
      dv[0].valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0].cmd    <= cmd4;
      dv[0].cmp    <= cmp4;
      dv[0].dz     <= dz4;
      dv[0].neg_re <= neg_re4;
      dv[0].neg_im <= neg_im4;
      dv[0].big_re <= hi_re >= den_x;
      dv[0].big_im <= hi_im >= den_x;
      dv[0].mag_re <= mag_re4;
      dv[0].mag_im <= mag_im4;
      dv[0].den    <= den4;
      dv[0].rem_re <= (hi_re >= den_x) ? '0 : hi_re;
      dv[0].rem_im <= (hi_im >= den_x) ? '0 : hi_im;
      dv[0].nlo_re <= num_re[DW-1:0];
      dv[0].nlo_im <= num_im[DW-1:0];
      dv[0].q_re   <= '0;
      dv[0].q_im   <= '0;
    end
  end

  for (genvar k = 0; k < DW; k++) begin : g_div
    logic [RW-1:0] tr_re, tr_im, dx;
    logic          ge_re, ge_im;

    assign tr_re = {dv[k].rem_re[RW-2:0], dv[k].nlo_re[DW-1]};
    assign tr_im = {dv[k].rem_im[RW-2:0], dv[k].nlo_im[DW-1]};
    assign dx    = RW'(dv[k].den);
    assign ge_re = tr_re >= dx;
    assign ge_im = tr_im >= dx;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1].valid <= 1'b0;
      end else if (adv) begin
        dv[k+1].valid <= dv[k].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv[k+1].cmd    <= dv[k].cmd;
        dv[k+1].cmp    <= dv[k].cmp;
        dv[k+1].dz     <= dv[k].dz;
        dv[k+1].neg_re <= dv[k].neg_re;
        dv[k+1].neg_im <= dv[k].neg_im;
        dv[k+1].big_re <= dv[k].big_re;
        dv[k+1].big_im <= dv[k].big_im;
        dv[k+1].mag_re <= dv[k].mag_re;
        dv[k+1].mag_im <= dv[k].mag_im;
        dv[k+1].den    <= dv[k].den;
        dv[k+1].rem_re <= ge_re ? tr_re - dx : tr_re;
        dv[k+1].rem_im <= ge_im ? tr_im - dx : tr_im;
        dv[k+1].nlo_re <= {dv[k].nlo_re[DW-2:0], 1'b0};
        dv[k+1].nlo_im <= {dv[k].nlo_im[DW-2:0], 1'b0};
        dv[k+1].q_re   <= {dv[k].q_re[DW-2:0], ge_re};
        dv[k+1].q_im   <= {dv[k].q_im[DW-2:0], ge_im};
      end
    end
  end

  // Final stage: pick the magnitude, saturate, and zero what the command
  // does not produce.
  logic          is_div, is_arith;
  logic          big_re_f, big_im_f;
  logic [PW-1:0] mf_re, mf_im;
  logic          ovf_re, ovf_im;
  logic [DW-1:0] sat_re, sat_im;
  logic [PW-1:0] pos_max, neg_max;

  assign pos_max  = PW'({1'b0, {(DW-1){1'b1}}});
  assign neg_max  = PW'({1'b1, {(DW-1){1'b0}}});
  assign is_div   = dv[DW].cmd == cau_pkg::CMD_DIV;
  assign is_arith = (dv[DW].cmd == cau_pkg::CMD_ADD) || (dv[DW].cmd == cau_pkg::CMD_SUB) ||
                    (dv[DW].cmd == cau_pkg::CMD_MUL) || (is_div && !dv[DW].dz);
  assign big_re_f = is_div && dv[DW].big_re;
  assign big_im_f = is_div && dv[DW].big_im;
  assign mf_re    = is_div ? PW'(dv[DW].q_re) : dv[DW].mag_re;
  assign mf_im    = is_div ? PW'(dv[DW].q_im) : dv[DW].mag_im;

  always_comb begin
    if (dv[DW].neg_re) begin
      ovf_re = big_re_f || (mf_re > neg_max);
      sat_re = ovf_re ? neg_max[DW-1:0] : DW'(-mf_re[DW-1:0]);
    end else begin
      ovf_re = big_re_f || (mf_re > pos_max);
      sat_re = ovf_re ? pos_max[DW-1:0] : mf_re[DW-1:0];
    end
    if (dv[DW].neg_im) begin
      ovf_im = big_im_f || (mf_im > neg_max);
      sat_im = ovf_im ? neg_max[DW-1:0] : DW'(-mf_im[DW-1:0]);
    end else begin
      ovf_im = big_im_f || (mf_im > pos_max);
      sat_im = ovf_im ? pos_max[DW-1:0] : mf_im[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (adv) begin
      ov <= dv[DW].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_re  <= is_arith ? sat_re : '0;
      o_im  <= is_arith ? sat_im : '0;
      o_ovf <= is_arith && (ovf_re || ovf_im);
      o_cmp <= dv[DW].cmp;
      o_dz  <= dv[DW].dz;
    end
  end

  assign m_axis_tvalid = ov;
  assign m_axis_tdata  = {{(cau_pkg::OUT_DATA_W-2*DW-3){1'b0}}, o_ovf, o_dz, o_cmp, o_im, o_re};

  a_dz_clean: assert property (@(posedge clk) disable iff (rst)
    ov && o_dz |-> o_re == '0 && o_im == '0 && !o_ovf && !o_cmp)
    else $error("divide by zero beat carries a result");

  a_flag_excl: assert property (@(posedge clk) disable iff (rst)
    ov && o_cmp |-> o_re == '0 && o_im == '0 && !o_ovf && !o_dz)
    else $error("compare beat carries a result");

  a_ovf_sat: assert property (@(posedge clk) disable iff (rst)
    ov && o_ovf |-> o_re == pos_max[DW-1:0] || o_re == neg_max[DW-1:0] ||
                    o_im == pos_max[DW-1:0] || o_im == neg_max[DW-1:0])
    else $error("overflow without a saturated part");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without an output stall");

  a_pipe_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(dv[DW].valid) && $stable(v1))
    else $error("pipeline moved during a stall");

endmodule
